@@ rtl/maps_pkg.sv @@
`timescale 1ns / 1ps

package maps_pkg;

    localparam int VALUE_W = 32;
    localparam int SUM_W   = 33;
    localparam int INDEX_W = 10;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_SHORT = 2'd1,
        STATUS_OVER  = 2'd2
    } status_t;

    typedef struct packed {
        logic valid;
        logic init;
    } pair_ctl_t;

endpackage

@@ rtl/maps_if.sv @@
`timescale 1ns / 1ps

interface maps_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [maps_pkg::VALUE_W-1:0] value;
    logic                                last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface maps_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [maps_pkg::SUM_W-1:0]   pair_sum;
    logic [maps_pkg::INDEX_W-1:0]        first_index;
    logic [maps_pkg::INDEX_W-1:0]        second_index;
    maps_pkg::status_t                   status;

    modport source (output valid, output pair_sum, output first_index, output second_index,
                    output status, input ready);
    modport sink   (input valid, input pair_sum, input first_index, input second_index,
                    input status, output ready);
endinterface

@@ rtl/maps_ram.sv @@
`timescale 1ns / 1ps

module maps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/maps_best.sv @@
`timescale 1ns / 1ps

module maps_best #(
    parameter int IDXW = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  maps_pkg::pair_ctl_t               ctl,
    input  logic signed [maps_pkg::SUM_W-1:0] sum,
    input  logic [IDXW-1:0]                   first,
    input  logic [IDXW-1:0]                   second,
    output logic signed [maps_pkg::SUM_W-1:0] best_sum,
    output logic [IDXW-1:0]                   best_first,
    output logic [IDXW-1:0]                   best_second
);

    logic signed [maps_pkg::SUM_W-1:0] best_sum_reg;
    logic [maps_pkg::SUM_W-1:0]        best_mag_reg;
    logic [IDXW-1:0]                   best_first_reg;
    logic [IDXW-1:0]                   best_second_reg;
    logic [maps_pkg::SUM_W-1:0]        mag;
    logic                              take;

    // The magnitude of the most negative sum still fits as an unsigned 33-bit value.
    assign mag  = sum[maps_pkg::SUM_W-1] ? (~sum + 1'b1) : sum;
    assign take = ctl.valid && (ctl.init || (mag < best_mag_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_sum_reg    <= '0;
            best_mag_reg    <= '0;
            best_first_reg  <= '0;
            best_second_reg <= '0;
        end
        else if (take)
        begin
            best_sum_reg    <= sum;
            best_mag_reg    <= mag;
            best_first_reg  <= first;
            best_second_reg <= second;
        end
    end

    assign best_sum    = best_sum_reg;
    assign best_first  = best_first_reg;
    assign best_second = best_second_reg;

endmodule

@@ rtl/min_abs_pair_sum_top.sv @@
// Sequence: after the closing word of a set of n values, every pair is searched and
// the result waits for a free output; a set of fewer than two values skips the search.
// Throughput: one value word per cycle while loading, then one pair per cycle in the
// search but at each row's ST_FIRST step; bound by the value memory's single read port.
// Reset: asynchronous, active low; clears control and best-pair state. The value
// memory is not cleared, since only entries written in the current set are read.
`timescale 1ns / 1ps

module min_abs_pair_sum_top #(
    parameter int MAX_ITEMS = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    maps_in_if.sink          in_ch,
    maps_out_if.source       out_ch
);

    localparam int IDXW = $clog2(MAX_ITEMS);
    localparam int CNTW = $clog2(MAX_ITEMS + 1);
    localparam int EXTW = (IDXW > maps_pkg::INDEX_W) ? IDXW : maps_pkg::INDEX_W;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ROW,
        ST_FIRST,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t                              state_reg;
    logic [CNTW-1:0]                     count_reg;
    logic                                ovf_reg;
    maps_pkg::status_t                   status_reg;
    logic [IDXW-1:0]                     i_reg;
    logic [IDXW-1:0]                     j_reg;
    logic [maps_pkg::VALUE_W-1:0]        vi_reg;
    logic                                init_reg;
    logic signed [maps_pkg::SUM_W-1:0]   sum_reg;
    maps_pkg::pair_ctl_t                 ctl_reg;
    logic [IDXW-1:0]                     pi_reg;
    logic [IDXW-1:0]                     pj_reg;
    logic                                out_valid_reg;
    logic signed [maps_pkg::SUM_W-1:0]   out_sum_reg;
    logic [maps_pkg::INDEX_W-1:0]        out_first_reg;
    logic [maps_pkg::INDEX_W-1:0]        out_second_reg;
    maps_pkg::status_t                   out_status_reg;

    logic                                in_acc;
    logic                                have_room;
    logic [CNTW-1:0]                     count_next;
    logic                                ovf_next;
    maps_pkg::pair_ctl_t                 ctl_next;
    logic                                out_valid_next;
    logic [CNTW-1:0]                     cnt_m1;
    logic [IDXW-1:0]                     nm1;
    logic [IDXW-1:0]                     i_inc;
    logic [IDXW-1:0]                     j_inc;
    logic [IDXW-1:0]                     rd_addr;
    logic [maps_pkg::VALUE_W-1:0]        rd_data;
    logic signed [maps_pkg::SUM_W-1:0]   pair_sum;
    logic                                out_free;
    logic signed [maps_pkg::SUM_W-1:0]   best_sum;
    logic [IDXW-1:0]                     best_first;
    logic [IDXW-1:0]                     best_second;
    logic [EXTW-1:0]                     first_ext;
    logic [EXTW-1:0]                     second_ext;

    assign in_ch.ready = (state_reg == ST_LOAD);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign have_room   = (count_reg < CNTW'(MAX_ITEMS));
    assign count_next  = have_room ? (count_reg + CNTW'(1)) : count_reg;
    assign ovf_next    = ovf_reg || !have_room;
    assign cnt_m1      = count_reg - CNTW'(1);
    assign nm1         = cnt_m1[IDXW-1:0];
    assign i_inc       = i_reg + IDXW'(1);
    assign j_inc       = j_reg + IDXW'(1);
    assign pair_sum    = {vi_reg[maps_pkg::VALUE_W-1], vi_reg}
                       + {rd_data[maps_pkg::VALUE_W-1], rd_data};
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign first_ext   = EXTW'(best_first);
    assign second_ext  = EXTW'(best_second);

    assign ctl_next.valid = (state_reg == ST_SCAN);
    assign ctl_next.init  = (state_reg == ST_SCAN) && init_reg;
    assign out_valid_next = ((state_reg == ST_EMIT) && out_free)
                          || (out_valid_reg && !out_ch.ready);

    always_comb
    begin
        unique case (state_reg)
            ST_ROW:   rd_addr = i_reg;
            ST_FIRST: rd_addr = i_inc;
            ST_SCAN:  rd_addr = (j_reg == nm1) ? i_inc : j_inc;
            default:  rd_addr = i_reg;
        endcase
    end

    maps_ram #(
        .WIDTH (maps_pkg::VALUE_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk     (clk),
        .wr_en   (in_acc && have_room),
        .wr_addr (count_reg[IDXW-1:0]),
        .wr_data (in_ch.value),
        .rd_en   (1'b1),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    maps_best #(
        .IDXW (IDXW)
    ) u_best (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl_reg),
        .sum         (sum_reg),
        .first       (pi_reg),
        .second      (pj_reg),
        .best_sum    (best_sum),
        .best_first  (best_first),
        .best_second (best_second)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            status_reg     <= maps_pkg::STATUS_OK;
            i_reg          <= '0;
            j_reg          <= '0;
            vi_reg         <= '0;
            init_reg       <= 1'b0;
            sum_reg        <= '0;
            ctl_reg        <= '0;
            pi_reg         <= '0;
            pj_reg         <= '0;
            out_valid_reg  <= 1'b0;
            out_sum_reg    <= '0;
            out_first_reg  <= '0;
            out_second_reg <= '0;
            out_status_reg <= maps_pkg::STATUS_OK;
        end
        else
        begin
            ctl_reg       <= ctl_next;
            out_valid_reg <= out_valid_next;

            unique case (state_reg)
                ST_LOAD:
                begin
                    if (in_acc)
                    begin
                        count_reg <= count_next;
                        ovf_reg   <= ovf_next;
                        if (in_ch.last)
                        begin
                            if (count_next < CNTW'(2))
                            begin
                                status_reg <= maps_pkg::STATUS_SHORT;
                                state_reg  <= ST_EMIT;
                            end
                            else
                            begin
                                status_reg <= ovf_next ? maps_pkg::STATUS_OVER
                                                       : maps_pkg::STATUS_OK;
                                i_reg      <= '0;
                                init_reg   <= 1'b1;
                                state_reg  <= ST_ROW;
                            end
                        end
                    end
                end

                ST_ROW:
                begin
                    state_reg <= ST_FIRST;
                end

                ST_FIRST:
                begin
                    vi_reg    <= rd_data;
                    j_reg     <= i_inc;
                    state_reg <= ST_SCAN;
                end

                ST_SCAN:
                begin
                    sum_reg       <= pair_sum;
                    pi_reg        <= i_reg;
                    pj_reg        <= j_reg;
                    init_reg      <= 1'b0;
                    if (j_reg != nm1)
                    begin
                        j_reg <= j_inc;
                    end
                    else if (i_inc == nm1)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        i_reg     <= i_inc;
                        state_reg <= ST_FIRST;
                    end
                end

                ST_DRAIN:
                begin
                    state_reg <= ST_EMIT;
                end

                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_status_reg <= status_reg;
                        if (status_reg == maps_pkg::STATUS_SHORT)
                        begin
                            out_sum_reg    <= '0;
                            out_first_reg  <= '0;
                            out_second_reg <= '0;
                        end
                        else
                        begin
                            out_sum_reg    <= best_sum;
                            out_first_reg  <= first_ext[maps_pkg::INDEX_W-1:0];
                            out_second_reg <= second_ext[maps_pkg::INDEX_W-1:0];
                        end
                        count_reg <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= ST_LOAD;
                    end
                end

                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.pair_sum     = out_sum_reg;
    assign out_ch.first_index  = out_first_reg;
    assign out_ch.second_index = out_second_reg;
    assign out_ch.status       = out_status_reg;

endmodule

@@ rtl/maps_check.sv @@
`timescale 1ns / 1ps

module maps_check (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                in_last,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [maps_pkg::SUM_W-1:0]   pair_sum,
    input logic [maps_pkg::INDEX_W-1:0]        first_index,
    input logic [maps_pkg::INDEX_W-1:0]        second_index,
    input logic [1:0]                          status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pair_sum)
            && $stable(first_index) && $stable(second_index) && $stable(status)))
        else $error("output word changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == maps_pkg::STATUS_OK || status == maps_pkg::STATUS_SHORT
            || status == maps_pkg::STATUS_OVER))
        else $error("undefined status code");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == maps_pkg::STATUS_SHORT)
            |-> (pair_sum == '0 && first_index == '0 && second_index == '0))
        else $error("short set word carries nonzero fields");

    a_last_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_last) |=> !in_ready)
        else $error("input taken right after the closing word");

endmodule

bind min_abs_pair_sum_top maps_check u_maps_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_last      (in_ch.last),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .pair_sum     (out_ch.pair_sum),
    .first_index  (out_ch.first_index),
    .second_index (out_ch.second_index),
    .status       (out_ch.status)
);
